FILE: rtl/core/ppm_ascii_stream_parser_assert.svh
// assertion macros shared by the ppm parser rtl
`ifndef PPM_ASCII_STREAM_PARSER_ASSERT_SVH
`define PPM_ASCII_STREAM_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// implication checked at every clock edge outside reset
`define PPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// invariant checked at every clock edge outside reset
`define PPM_ASSERT_INV(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);
`else
`define PPM_ASSERT_IMP(lbl, ante, cons, msg)
`define PPM_ASSERT_INV(lbl, expr, msg)
`endif

`endif

FILE: rtl/core/ppm_pkg.sv
// types and constants for the ascii ppm stream parser
package ppm_pkg;

  // number and dimension sizing
  localparam int DIM_BITS = 16;
  localparam int MAG_BITS = DIM_BITS + 1;
  localparam int MUL_BITS = MAG_BITS + 4;
  localparam int CNT_BITS = 2 * DIM_BITS;
  localparam logic [MAG_BITS-1:0] NUM_CAP = MAG_BITS'(1) << DIM_BITS;
  localparam logic [MAG_BITS-1:0] COLOR_MAX = MAG_BITS'(255);

  // output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // parser phases
  localparam logic [3:0] PH_MAGIC0 = 4'd0;
  localparam logic [3:0] PH_MAGIC1 = 4'd1;
  localparam logic [3:0] PH_WIDTH  = 4'd2;
  localparam logic [3:0] PH_HEIGHT = 4'd3;
  localparam logic [3:0] PH_LIMIT  = 4'd4;
  localparam logic [3:0] PH_RED    = 4'd5;
  localparam logic [3:0] PH_GREEN  = 4'd6;
  localparam logic [3:0] PH_BLUE   = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_WIDTH  = 3'd1;
  localparam logic [2:0] ERR_HEIGHT = 3'd2;
  localparam logic [2:0] ERR_LIMIT  = 3'd3;
  localparam logic [2:0] ERR_PIXEL  = 3'd4;
  localparam logic [2:0] ERR_RANGE  = 3'd5;

  // characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  color_limit;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] pixel_index;
    logic        final_pixel;
    logic [2:0]  error_code;
    logic        last_of_run;
  } result_t;

endpackage

FILE: rtl/core/ppm_ascii_stream_parser.sv
// ascii p3 pixmap parser taking one text byte per transfer
//
// ppm_ascii_stream_parser takes the text of a P3 pixmap one byte per input
// transfer (in_tlast high marks end of file, its byte is ignored) and emits
// header, pixel and error results. Each byte is fully parsed in the cycle it
// is accepted: the parser state updates at that edge and the zero, one or
// two results it causes are written into a four entry output queue. The
// input is ready while the queue has room for two results, so one byte is
// taken every cycle as long as the output side keeps up; bytes that cause two
// results (a number closing on an error, or end of file after a number) are
// limited by the output port, which sends one result per cycle. There is no
// clearing pass after reset. out_tlast marks the last result caused by one
// input byte, out_tuser carries the result kind. After an error or the last
// pixel, bytes are dropped until end of file, which restarts the parser.
`include "ppm_ascii_stream_parser_assert.svh"

module ppm_ascii_stream_parser (
  input  logic          clk,
  input  logic          rst_n,
  // input byte stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] byte_in
  input  logic          in_tlast,   // end_of_stream
  // result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // [15:0] image_width, [31:16] image_height,
                                    // [39:32] color_limit, [47:40] red,
                                    // [55:48] green, [63:56] blue,
                                    // [95:64] pixel_index, [96] final_pixel,
                                    // [99:97] error_code, [103:100] zero
  output logic [1:0]    out_tuser,  // [1:0] kind
  output logic          out_tlast   // last_of_run
);

  localparam int DIM_BITS = ppm_pkg::DIM_BITS;
  localparam int MAG_BITS = ppm_pkg::MAG_BITS;
  localparam int MUL_BITS = ppm_pkg::MUL_BITS;
  localparam int CNT_BITS = ppm_pkg::CNT_BITS;
  localparam int QPTR_BITS = ppm_pkg::QPTR_BITS;
  localparam int QCNT_BITS = ppm_pkg::QCNT_BITS;

  // parser state
  logic [3:0]          phase_r, phase_nxt;
  logic                in_comment_r, in_comment_nxt;
  logic                num_active_r, num_active_nxt;
  logic                sign_seen_r, sign_seen_nxt;
  logic                neg_r, neg_nxt;
  logic [MAG_BITS-1:0] acc_r, acc_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [7:0]          limit_r, limit_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          green_r, green_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] total_r, total_nxt;
  logic                range_bad_r, range_bad_nxt;

  // output queue
  ppm_pkg::result_t     q_mem [ppm_pkg::QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                 in_accept;
  logic                 out_accept;
  logic [1:0]           nres;
  ppm_pkg::result_t     slot0, slot1;
  ppm_pkg::result_t     head;

  logic [7:0] byte_in;
  logic       eos;

  assign byte_in   = in_tdata;
  assign eos       = in_tlast;
  assign in_tready = (cnt_r <= QCNT_BITS'(ppm_pkg::QDEPTH - 2));
  assign in_accept = in_tvalid && in_tready;

  // error code of the field being read in a phase
  function automatic logic [2:0] field_code(input logic [3:0] ph);
    logic [2:0] code;
    code = ppm_pkg::ERR_MAGIC;
    case (ph)
      ppm_pkg::PH_WIDTH:  code = ppm_pkg::ERR_WIDTH;
      ppm_pkg::PH_HEIGHT: code = ppm_pkg::ERR_HEIGHT;
      ppm_pkg::PH_LIMIT:  code = ppm_pkg::ERR_LIMIT;
      ppm_pkg::PH_RED, ppm_pkg::PH_GREEN, ppm_pkg::PH_BLUE: code = ppm_pkg::ERR_PIXEL;
      default:            code = ppm_pkg::ERR_MAGIC;
    endcase
    return code;
  endfunction

  function automatic ppm_pkg::result_t err_result(input logic [2:0] code);
    ppm_pkg::result_t res;
    res = '0;
    res.kind = ppm_pkg::KIND_ERROR;
    res.error_code = code;
    return res;
  endfunction

  // single pass parse of the accepted byte
  always_comb begin
    logic                is_digit;
    logic                is_space;
    logic                do_fin;
    logic [MAG_BITS-1:0] mag;
    logic                mag_neg;
    logic                pix_bad;
    logic                pix_fin;
    logic [MUL_BITS-1:0] acc_ext;
    logic                fa, fb;
    ppm_pkg::result_t    res_a, res_b;

    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    num_active_nxt = num_active_r;
    sign_seen_nxt  = sign_seen_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    limit_nxt      = limit_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    range_bad_nxt  = range_bad_r;

    is_digit = (byte_in >= ppm_pkg::CH_0) && (byte_in <= ppm_pkg::CH_9);
    is_space = byte_in inside {ppm_pkg::CH_SP, [ppm_pkg::CH_TAB:ppm_pkg::CH_CR]};
    mag      = acc_r;
    mag_neg  = neg_r && (acc_r != '0);
    pix_bad  = 1'b0;
    pix_fin  = 1'b0;
    acc_ext  = '0;
    fa       = 1'b0;
    fb       = 1'b0;
    res_a    = '0;
    res_b    = '0;

    // a pending number closes on end of file or on a non-digit byte
    do_fin = num_active_r && (eos ||
             (!is_digit && !in_comment_r && phase_r != ppm_pkg::PH_MAGIC0 &&
              phase_r != ppm_pkg::PH_MAGIC1 && phase_r != ppm_pkg::PH_DONE));

    if (do_fin) begin
      num_active_nxt = 1'b0;
      sign_seen_nxt  = 1'b0;
      neg_nxt        = 1'b0;
      acc_nxt        = '0;
      case (phase_r)
        ppm_pkg::PH_WIDTH: begin
          if (mag_neg || mag == '0 || mag[DIM_BITS]) begin
            fa = 1'b1;
            res_a = err_result(ppm_pkg::ERR_WIDTH);
            phase_nxt = ppm_pkg::PH_DONE;
          end else begin
            width_nxt = mag[DIM_BITS-1:0];
            phase_nxt = ppm_pkg::PH_HEIGHT;
          end
        end
        ppm_pkg::PH_HEIGHT: begin
          if (mag_neg || mag == '0 || mag[DIM_BITS]) begin
            fa = 1'b1;
            res_a = err_result(ppm_pkg::ERR_HEIGHT);
            phase_nxt = ppm_pkg::PH_DONE;
          end else begin
            height_nxt = mag[DIM_BITS-1:0];
            phase_nxt = ppm_pkg::PH_LIMIT;
          end
        end
        ppm_pkg::PH_LIMIT: begin
          if (mag_neg || mag == '0 || mag > ppm_pkg::COLOR_MAX) begin
            fa = 1'b1;
            res_a = err_result(ppm_pkg::ERR_LIMIT);
            phase_nxt = ppm_pkg::PH_DONE;
          end else begin
            limit_nxt = mag[7:0];
            total_nxt = CNT_BITS'(width_r) * CNT_BITS'(height_r);
            count_nxt = '0;
            fa = 1'b1;
            res_a.kind = ppm_pkg::KIND_HEADER;
            res_a.image_width = 16'(width_r);
            res_a.image_height = 16'(height_r);
            res_a.color_limit = mag[7:0];
            phase_nxt = ppm_pkg::PH_RED;
          end
        end
        ppm_pkg::PH_RED: begin
          red_nxt = mag[7:0];
          range_bad_nxt = mag_neg || (mag > MAG_BITS'(limit_r));
          phase_nxt = ppm_pkg::PH_GREEN;
        end
        ppm_pkg::PH_GREEN: begin
          green_nxt = mag[7:0];
          range_bad_nxt = range_bad_r || mag_neg || (mag > MAG_BITS'(limit_r));
          phase_nxt = ppm_pkg::PH_BLUE;
        end
        ppm_pkg::PH_BLUE: begin
          pix_bad = range_bad_r || mag_neg || (mag > MAG_BITS'(limit_r));
          range_bad_nxt = 1'b0;
          fa = 1'b1;
          if (pix_bad) begin
            res_a = err_result(ppm_pkg::ERR_RANGE);
            phase_nxt = ppm_pkg::PH_DONE;
          end else begin
            pix_fin = ((count_r + CNT_BITS'(1)) == total_r);
            res_a.kind = ppm_pkg::KIND_PIXEL;
            res_a.image_width = 16'(width_r);
            res_a.image_height = 16'(height_r);
            res_a.color_limit = limit_r;
            res_a.red = red_r;
            res_a.green = green_r;
            res_a.blue = mag[7:0];
            res_a.pixel_index = 32'(count_r);
            res_a.final_pixel = pix_fin;
            count_nxt = count_r + CNT_BITS'(1);
            phase_nxt = pix_fin ? ppm_pkg::PH_DONE : ppm_pkg::PH_RED;
          end
        end
        default: ;
      endcase
    end

    if (eos) begin
      // premature end reports the field being read, then full restart
      if (phase_nxt != ppm_pkg::PH_DONE) begin
        fb = 1'b1;
        res_b = err_result(field_code(phase_nxt));
      end
      phase_nxt      = ppm_pkg::PH_MAGIC0;
      in_comment_nxt = 1'b0;
      num_active_nxt = 1'b0;
      sign_seen_nxt  = 1'b0;
      neg_nxt        = 1'b0;
      acc_nxt        = '0;
      width_nxt      = '0;
      height_nxt     = '0;
      limit_nxt      = '0;
      red_nxt        = '0;
      green_nxt      = '0;
      count_nxt      = '0;
      total_nxt      = '0;
      range_bad_nxt  = 1'b0;
    end else if (phase_r == ppm_pkg::PH_DONE) begin
      // drop bytes until end of file
    end else if (phase_r == ppm_pkg::PH_MAGIC0) begin
      if (!is_space) begin
        if (byte_in == ppm_pkg::CH_P) begin
          phase_nxt = ppm_pkg::PH_MAGIC1;
        end else begin
          fb = 1'b1;
          res_b = err_result(ppm_pkg::ERR_MAGIC);
          phase_nxt = ppm_pkg::PH_DONE;
        end
      end
    end else if (phase_r == ppm_pkg::PH_MAGIC1) begin
      if (byte_in == ppm_pkg::CH_3) begin
        phase_nxt = ppm_pkg::PH_WIDTH;
      end else begin
        fb = 1'b1;
        res_b = err_result(ppm_pkg::ERR_MAGIC);
        phase_nxt = ppm_pkg::PH_DONE;
      end
    end else if (in_comment_r) begin
      if (byte_in == ppm_pkg::CH_NL) begin
        in_comment_nxt = 1'b0;
      end
    end else if (phase_nxt == ppm_pkg::PH_DONE) begin
      // closing number failed or finished the image
    end else if (is_digit) begin
      acc_ext = (MUL_BITS'(acc_r) << 3) + (MUL_BITS'(acc_r) << 1) +
                MUL_BITS'(byte_in - ppm_pkg::CH_0);
      acc_nxt = (acc_ext > MUL_BITS'(ppm_pkg::NUM_CAP)) ? ppm_pkg::NUM_CAP :
                acc_ext[MAG_BITS-1:0];
      num_active_nxt = 1'b1;
    end else if (sign_seen_nxt) begin
      fb = 1'b1;
      res_b = err_result(field_code(phase_nxt));
      phase_nxt = ppm_pkg::PH_DONE;
    end else if (byte_in == ppm_pkg::CH_PLUS || byte_in == ppm_pkg::CH_MINUS) begin
      sign_seen_nxt = 1'b1;
      neg_nxt = (byte_in == ppm_pkg::CH_MINUS);
    end else if (is_space) begin
      // separator
    end else if (byte_in == ppm_pkg::CH_HASH && phase_nxt != ppm_pkg::PH_GREEN &&
                 phase_nxt != ppm_pkg::PH_BLUE) begin
      in_comment_nxt = 1'b1;
    end else begin
      fb = 1'b1;
      res_b = err_result(field_code(phase_nxt));
      phase_nxt = ppm_pkg::PH_DONE;
    end

    // order results: a closed number's result goes ahead of a later error
    nres  = {1'b0, fa} + {1'b0, fb};
    slot0 = fa ? res_a : res_b;
    slot1 = res_b;
    slot0.last_of_run = (nres == 2'd1);
    slot1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ppm_pkg::PH_MAGIC0;
      in_comment_r <= 1'b0;
      num_active_r <= 1'b0;
      sign_seen_r  <= 1'b0;
      neg_r        <= 1'b0;
      acc_r        <= '0;
      width_r      <= '0;
      height_r     <= '0;
      limit_r      <= '0;
      red_r        <= '0;
      green_r      <= '0;
      count_r      <= '0;
      total_r      <= '0;
      range_bad_r  <= 1'b0;
    end else if (in_accept) begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      num_active_r <= num_active_nxt;
      sign_seen_r  <= sign_seen_nxt;
      neg_r        <= neg_nxt;
      acc_r        <= acc_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      limit_r      <= limit_nxt;
      red_r        <= red_nxt;
      green_r      <= green_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      range_bad_r  <= range_bad_nxt;
    end
  end

  // result queue: up to two writes per accepted byte, one read per transfer
  assign out_accept = out_tvalid && out_tready;
  assign cnt_nxt    = cnt_r + (in_accept ? QCNT_BITS'(nres) : '0)
                            - (out_accept ? QCNT_BITS'(1) : '0);

  always_ff @(posedge clk) begin
    if (in_accept && nres != 2'd0) begin
      q_mem[wr_ptr_r] <= slot0;
    end
    if (in_accept && nres == 2'd2) begin
      q_mem[wr_ptr_r + QPTR_BITS'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(nres);
      end
      if (out_accept) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last_of_run;
  assign out_tdata  = {4'b0000, head.error_code, head.final_pixel, head.pixel_index,
                       head.blue, head.green, head.red, head.color_limit,
                       head.image_height, head.image_width};

  // queue occupancy never passes its depth
  `PPM_ASSERT_INV(a_queue_bound, cnt_r <= QCNT_BITS'(ppm_pkg::QDEPTH), "queue overflow")

  // no number can be open inside a comment
  `PPM_ASSERT_IMP(a_comment_no_number, in_comment_r, !num_active_r, "number open in comment")

  // while pixels are pending the index stays below the pixel total
  `PPM_ASSERT_IMP(a_pixel_index_bound,
    phase_r == ppm_pkg::PH_RED || phase_r == ppm_pkg::PH_GREEN || phase_r == ppm_pkg::PH_BLUE,
    count_r < total_r, "pixel count beyond image")

  // a delivered pixel never exceeds its color limit
  `PPM_ASSERT_IMP(a_pixel_in_range, out_tvalid && out_tuser == ppm_pkg::KIND_PIXEL,
    head.red <= head.color_limit && head.green <= head.color_limit &&
    head.blue <= head.color_limit, "pixel above color limit")

endmodule
